[design/rws_pkg.sv]
// Shared types and constants for the roulette-wheel selector.
// Used by rws_cell, rws_fitness and roulette_wheel_selector; depends on nothing.
`default_nettype none

package rws_pkg;

	// Operation codes carried by the opcode input.
	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} opcode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Top-level control states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_FIT,
		S_LOAD_WRITE,
		S_DRAW_GOAL,
		S_DRAW_CMP,
		S_DRAW_SCAN
	} ctl_state_t;

	// Fitness unit states.
	typedef enum logic [1:0] {
		F_IDLE,
		F_SQUARE,
		F_SETUP,
		F_DIVIDE
	} fit_state_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic cmp;
		logic shift;
	} cell_ctrl_t;

	// Field widths and fixed constants.
	localparam int DRAW_W     = 14;
	localparam int ERR_W      = 32;
	localparam int FIT_W      = 16;
	localparam int SEL_W      = 5;
	localparam int QUOT_W     = 17;
	localparam int QUOT_STEPS = 17;
	localparam logic [DRAW_W-1:0] DRAW_SCALE = 14'd10000;
	localparam logic [FIT_W-1:0]  FIT_MAX    = 16'hFFFF;

endpackage

`default_nettype wire

[design/rws_cell.sv]
// One cell of the prefix-sum chain: holds a scaled prefix sum and a hit flag.
// Depends on rws_pkg for the cell control struct.
`default_nettype none

module rws_cell #(
	parameter int DATA_W = 35
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [DATA_W-1:0]   wr_data,
	input  wire rws_pkg::cell_ctrl_t ctrl,
	input  wire logic [DATA_W-1:0]   goal,
	input  wire logic                hit_in,
	output logic                     hit
);

	logic [DATA_W-1:0] sum_q;
	logic              hit_q;

	// The stored sum is written once per load; the hit flag is either set by
	// the compare against the broadcast goal or taken from the right neighbor.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_q <= wr_data;
		end
		if (ctrl.cmp) begin
			hit_q <= (sum_q >= goal);
		end else if (ctrl.shift) begin
			hit_q <= hit_in;
		end
	end

	assign hit = hit_q;

endmodule

`default_nettype wire

[design/rws_fitness.sv]
// Fitness unit: absolute error, its square, and a bit-serial restoring divide
// giving round(2^48 / (2^32 + err^2)) saturated to 16 bits. Depends on rws_pkg.
`default_nettype none

module rws_fitness (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rws_pkg::ERR_W-1:0]   target,
	input  wire logic [rws_pkg::ERR_W-1:0]   pred,
	output logic                             done,
	output logic [rws_pkg::ERR_W-1:0]        abs_error,
	output logic [rws_pkg::FIT_W-1:0]        fitness
);

	rws_pkg::fit_state_t state_q, state_d;

	logic [rws_pkg::ERR_W-1:0]    err_q;
	logic [63:0]                  sq_q;
	logic [63:0]                  den_q;
	logic [63:0]                  rem_q;
	logic [rws_pkg::QUOT_W-1:0]   numlo_q;
	logic [rws_pkg::QUOT_W-1:0]   quot_q;
	logic [4:0]                   step_q;
	logic                         done_q;

	logic [63:0] den_c;
	logic [63:0] num_c;
	logic [64:0] trial_c;

	// Denominator and rounded numerator; both additions set a single bit above
	// the operand's low part, so they reduce to incrementers.
	assign den_c   = sq_q + 64'h0000_0001_0000_0000;
	assign num_c   = {1'b0, den_c[63:1]} + 64'h0001_0000_0000_0000;
	assign trial_c = {rem_q, numlo_q[rws_pkg::QUOT_W-1]} - {1'b0, den_q};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rws_pkg::F_IDLE: begin
				if (start) begin
					state_d = rws_pkg::F_SQUARE;
				end
			end
			rws_pkg::F_SQUARE: state_d = rws_pkg::F_SETUP;
			rws_pkg::F_SETUP:  state_d = rws_pkg::F_DIVIDE;
			rws_pkg::F_DIVIDE: begin
				if (step_q == 5'd0) begin
					state_d = rws_pkg::F_IDLE;
				end
			end
			default: state_d = rws_pkg::F_IDLE;
		endcase
	end

	// State register and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rws_pkg::F_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == rws_pkg::F_DIVIDE) && (step_q == 5'd0);
		end
	end

	// Datapath: one quotient bit per divide cycle. The quotient is below 2^17,
	// so the partial remainder starts from the numerator's top bits.
	always_ff @(posedge clk) begin
		case (state_q)
			rws_pkg::F_IDLE: begin
				if (start) begin
					err_q <= (target >= pred) ? (target - pred) : (pred - target);
				end
			end
			rws_pkg::F_SQUARE: begin
				sq_q <= 64'(err_q) * 64'(err_q);
			end
			rws_pkg::F_SETUP: begin
				den_q   <= den_c;
				rem_q   <= 64'(num_c[63:rws_pkg::QUOT_W]);
				numlo_q <= num_c[rws_pkg::QUOT_W-1:0];
				quot_q  <= '0;
				step_q  <= 5'(rws_pkg::QUOT_STEPS - 1);
			end
			rws_pkg::F_DIVIDE: begin
				if (!trial_c[64]) begin
					rem_q <= trial_c[63:0];
				end else begin
					rem_q <= {rem_q[62:0], numlo_q[rws_pkg::QUOT_W-1]};
				end
				quot_q  <= {quot_q[rws_pkg::QUOT_W-2:0], ~trial_c[64]};
				numlo_q <= {numlo_q[rws_pkg::QUOT_W-2:0], 1'b0};
				step_q  <= step_q - 5'd1;
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign abs_error = err_q;
	assign fitness   = quot_q[rws_pkg::QUOT_W-1] ? rws_pkg::FIT_MAX
	                                             : quot_q[rws_pkg::FIT_W-1:0];

endmodule

`default_nettype wire

[design/roulette_wheel_selector.sv]
// Roulette-wheel selector: top level with control, running total and the cell chain.
// Depends on rws_pkg, rws_fitness and rws_cell.
//
// A command is taken when start is high and busy is low; each command yields
// one result shown for exactly one cycle with done high, and the receiver
// cannot stall it. A load waits for the fitness unit (square, setup, then the
// bit-serial divide in the fitness unit, one quotient bit per cycle, 17 bits)
// and then writes the next cell, or writes nothing when the store is full.
// A draw forms the goal product, runs the parallel compare in every cell and
// then shifts the hit flags one cell per cycle toward the head of the chain
// until the first hit or the last loaded candidate arrives; the chosen index
// is at most loaded count - 1. A draw with nothing loaded answers from the
// goal state with an empty status. busy drops in the done cycle, so the
// next command can be taken while a result is shown. target_length may be
// written only while no command is in flight.
`default_nettype none

module roulette_wheel_selector #(
	parameter int SLOTS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [rws_pkg::ERR_W-1:0]    target_length,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [0:0]                   opcode,
	input  wire logic                         first,
	input  wire logic [rws_pkg::ERR_W-1:0]    predicted_length,
	input  wire logic [rws_pkg::DRAW_W-1:0]   draw,
	output logic                              done,
	output logic [rws_pkg::ERR_W-1:0]         abs_error,
	output logic [rws_pkg::FIT_W-1:0]         adjusted_fitness,
	output logic [rws_pkg::SEL_W-1:0]         selected_index,
	output logic [1:0]                        status
);

	localparam int SUM_W  = $clog2(SLOTS * 65535 + 1);
	localparam int GOAL_W = SUM_W + rws_pkg::DRAW_W;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int EXT_W  = (IDX_W > rws_pkg::SEL_W) ? IDX_W : rws_pkg::SEL_W;

	rws_pkg::ctl_state_t state_q, state_d;

	logic [rws_pkg::ERR_W-1:0]  target_q;
	logic [CNT_W-1:0]           count_q;
	logic [SUM_W-1:0]           total_q;
	rws_pkg::opcode_t           op_q;
	logic [rws_pkg::DRAW_W-1:0] draw_q;
	logic [GOAL_W-1:0]          goal_q;
	logic [IDX_W-1:0]           scan_idx_q;

	logic                         done_q;
	logic [rws_pkg::ERR_W-1:0]    abs_error_q;
	logic [rws_pkg::FIT_W-1:0]    fitness_q;
	logic [rws_pkg::SEL_W-1:0]    sel_q;
	rws_pkg::status_t             status_q;

	logic                         accept;
	logic                         full;
	logic                         last_scan;
	logic                         emit;
	rws_pkg::status_t             emit_status;
	rws_pkg::cell_ctrl_t          cell_ctrl;
	logic                         cell_write;
	logic [GOAL_W-1:0]            wr_data;
	logic [EXT_W-1:0]             sel_ext;

	logic                         fit_start;
	logic                         fit_done;
	logic [rws_pkg::ERR_W-1:0]    fit_err;
	logic [rws_pkg::FIT_W-1:0]    fit_val;

	logic                         hits [SLOTS+1];

	assign busy      = (state_q != rws_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign fit_start = accept && (opcode == rws_pkg::OP_LOAD);
	assign full      = (count_q >= CNT_W'(SLOTS));
	assign last_scan = (CNT_W'(scan_idx_q) == (count_q - CNT_W'(1)));
	assign wr_data   = GOAL_W'(total_q) * GOAL_W'(rws_pkg::DRAW_SCALE);
	assign sel_ext   = EXT_W'(scan_idx_q);

	// Fitness computation for loads.
	rws_fitness u_fitness (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (fit_start),
		.target    (target_q),
		.pred      (predicted_length),
		.done      (fit_done),
		.abs_error (fit_err),
		.fitness   (fit_val)
	);

	// Chain of cells; each hit flag moves one cell toward the head per shift.
	assign hits[SLOTS] = 1'b0;
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic wr_en;
		assign wr_en = cell_write && (count_q[IDX_W-1:0] == IDX_W'(i));
		rws_cell #(
			.DATA_W (GOAL_W)
		) u_cell (
			.clk     (clk),
			.wr_en   (wr_en),
			.wr_data (wr_data),
			.ctrl    (cell_ctrl),
			.goal    (goal_q),
			.hit_in  (hits[i+1]),
			.hit     (hits[i])
		);
	end

	// Next state and control outputs.
	always_comb begin
		state_d         = state_q;
		emit            = 1'b0;
		emit_status     = rws_pkg::ST_OK;
		cell_ctrl.cmp   = 1'b0;
		cell_ctrl.shift = 1'b0;
		cell_write      = 1'b0;
		case (state_q)
			rws_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (opcode == rws_pkg::OP_LOAD) ? rws_pkg::S_LOAD_FIT
					                                       : rws_pkg::S_DRAW_GOAL;
				end
			end
			rws_pkg::S_LOAD_FIT: begin
				if (fit_done) begin
					if (full) begin
						emit        = 1'b1;
						emit_status = rws_pkg::ST_FULL;
						state_d     = rws_pkg::S_IDLE;
					end else begin
						state_d = rws_pkg::S_LOAD_WRITE;
					end
				end
			end
			rws_pkg::S_LOAD_WRITE: begin
				cell_write = 1'b1;
				emit       = 1'b1;
				state_d    = rws_pkg::S_IDLE;
			end
			rws_pkg::S_DRAW_GOAL: begin
				if (count_q == '0) begin
					emit        = 1'b1;
					emit_status = rws_pkg::ST_EMPTY;
					state_d     = rws_pkg::S_IDLE;
				end else begin
					state_d = rws_pkg::S_DRAW_CMP;
				end
			end
			rws_pkg::S_DRAW_CMP: begin
				cell_ctrl.cmp = 1'b1;
				state_d       = rws_pkg::S_DRAW_SCAN;
			end
			rws_pkg::S_DRAW_SCAN: begin
				if (hits[0] || last_scan) begin
					emit    = 1'b1;
					state_d = rws_pkg::S_IDLE;
				end else begin
					cell_ctrl.shift = 1'b1;
				end
			end
			default: state_d = rws_pkg::S_IDLE;
		endcase
	end

	// Control state, population state and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rws_pkg::S_IDLE;
			target_q <= '0;
			count_q  <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cfg_we) begin
				target_q <= target_length;
			end
			if (fit_start && first) begin
				count_q <= '0;
				total_q <= '0;
			end else if (state_q == rws_pkg::S_LOAD_FIT && fit_done && !full) begin
				total_q <= total_q + SUM_W'(fit_val);
			end else if (cell_write) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Command capture, draw goal, scan index and the result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= rws_pkg::opcode_t'(opcode);
			draw_q <= draw;
		end
		if (state_q == rws_pkg::S_DRAW_GOAL) begin
			goal_q <= GOAL_W'(draw_q) * GOAL_W'(total_q);
		end
		if (cell_ctrl.cmp) begin
			scan_idx_q <= '0;
		end else if (cell_ctrl.shift) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		if (emit) begin
			status_q <= emit_status;
			if (op_q == rws_pkg::OP_LOAD) begin
				abs_error_q <= fit_err;
				fitness_q   <= fit_val;
				sel_q       <= '0;
			end else begin
				abs_error_q <= '0;
				fitness_q   <= '0;
				sel_q       <= (emit_status == rws_pkg::ST_EMPTY) ? '0
				                                                   : sel_ext[rws_pkg::SEL_W-1:0];
			end
		end
	end

	assign done             = done_q;
	assign abs_error        = abs_error_q;
	assign adjusted_fitness = fitness_q;
	assign selected_index   = sel_q;
	assign status           = status_q;

endmodule

`default_nettype wire

[verif/rws_checker.sv]
// Checker for the roulette-wheel selector: mirrors the target register and the
// candidate store, predicts every command's result and compares it field by field.
// Depends on rws_pkg for the opcode and status codes.
`timescale 1ns / 1ps

module rws_checker #(
	parameter int SLOTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] target_length,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [0:0]  opcode,
	input  wire logic        first,
	input  wire logic [31:0] predicted_length,
	input  wire logic [13:0] draw,
	input  wire logic        done,
	input  wire logic [31:0] abs_error,
	input  wire logic [15:0] adjusted_fitness,
	input  wire logic [4:0]  selected_index,
	input  wire logic [1:0]  status,
	output int               mismatches,
	output int               pending
);

	typedef struct packed {
		logic [31:0]      err;
		logic [15:0]      fit;
		logic [4:0]       sel;
		rws_pkg::status_t st;
	} selector_result_t;

	// Mirror of the block's register and candidate store.
	logic [31:0] goal_length;
	logic [31:0] cumulative_fitness [SLOTS];
	logic [31:0] fitness_sum;
	int          population;

	// Results still owed by the block, oldest first.
	selector_result_t owed_results[$];

	task automatic report(input string field, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, field,
				want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : model
		logic [63:0]      den;
		logic [63:0]      num;
		logic [63:0]      quot;
		logic [63:0]      goal;
		selector_result_t want;
		int               pick;
		bit               hit;

		if (!arst_n) begin
			goal_length = '0;
			fitness_sum = '0;
			population  = 0;
			owed_results.delete();
			pending     = 0;
		end else begin
			// Compare a shown result with the oldest expectation.
			if (done) begin
				if (owed_results.size() == 0) begin
					report("unexpected result", 0, 1);
				end else begin
					want = owed_results.pop_front();
					if (abs_error !== want.err) begin
						report("abs_error", want.err, abs_error);
					end
					if (adjusted_fitness !== want.fit) begin
						report("adjusted_fitness", want.fit, adjusted_fitness);
					end
					if (selected_index !== want.sel) begin
						report("selected_index", want.sel, selected_index);
					end
					if (status !== want.st) begin
						report("status", want.st, status);
					end
				end
			end

			// Predict the result of a command accepted at this edge.
			if (start && !busy) begin
				want = '{err: '0, fit: '0, sel: '0, st: rws_pkg::ST_OK};
				if (opcode == rws_pkg::OP_LOAD) begin
					want.err = (goal_length >= predicted_length) ?
						goal_length - predicted_length : predicted_length - goal_length;
					// Fitness is 2^48 / (2^32 + err^2), rounded half up and saturated.
					den  = 64'h1_0000_0000 + {32'b0, want.err} * {32'b0, want.err};
					num  = 64'h1_0000_0000_0000 + (den >> 1);
					quot = num / den;
					want.fit = (quot > 64'hFFFF) ? rws_pkg::FIT_MAX : quot[15:0];
					if (first) begin
						population  = 0;
						fitness_sum = '0;
					end
					if (population >= SLOTS) begin
						want.st = rws_pkg::ST_FULL;
					end else begin
						fitness_sum = fitness_sum + want.fit;
						cumulative_fitness[population] = fitness_sum;
						population++;
					end
				end else if (population == 0) begin
					want.st = rws_pkg::ST_EMPTY;
				end else begin
					// First candidate whose scaled prefix reaches r times the total;
					// the last loaded one when none does.
					goal = {50'b0, draw} * {32'b0, fitness_sum};
					pick = population - 1;
					hit  = 1'b0;
					for (int j = 0; j < population && !hit; j++) begin
						if ({32'b0, cumulative_fitness[j]} * 64'(rws_pkg::DRAW_SCALE) >= goal)
						begin
							pick = j;
							hit  = 1'b1;
						end
					end
					want.sel = 5'(pick);
				end
				owed_results.push_back(want);
			end

			if (cfg_we) begin
				goal_length = target_length;
			end
			pending = owed_results.size();
		end
	end

endmodule

[verif/tb_roulette_wheel_selector.sv]
// Testbench top for the roulette-wheel selector: clock, reset, command and
// target stimulus, and the verdict. Depends on rws_pkg, rws_checker and the block.
`timescale 1ns / 1ps

module tb_roulette_wheel_selector;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 98;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] target_length;
	logic        start;
	logic        busy;
	logic [0:0]  opcode;
	logic        first;
	logic [31:0] predicted_length;
	logic [13:0] draw;
	logic        done;
	logic [31:0] abs_error;
	logic [15:0] adjusted_fitness;
	logic [4:0]  selected_index;
	logic [1:0]  status;
	int          mismatches;
	int          pending;

	// Stimulus bookkeeping.
	bit start_level;
	bit idle_on;
	int loads_sent;
	int draws_sent;
	int wide_draws;
	int targets_written;
	int watchdog_cycles;

	roulette_wheel_selector #(.SLOTS(32)) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.target_length    (target_length),
		.start            (start),
		.busy             (busy),
		.opcode           (opcode),
		.first            (first),
		.predicted_length (predicted_length),
		.draw             (draw),
		.done             (done),
		.abs_error        (abs_error),
		.adjusted_fitness (adjusted_fitness),
		.selected_index   (selected_index),
		.status           (status)
	);

	rws_checker #(.SLOTS(32)) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.target_length    (target_length),
		.start            (start),
		.busy             (busy),
		.opcode           (opcode),
		.first            (first),
		.predicted_length (predicted_length),
		.draw             (draw),
		.done             (done),
		.abs_error        (abs_error),
		.adjusted_fitness (adjusted_fitness),
		.selected_index   (selected_index),
		.status           (status),
		.mismatches       (mismatches),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Presents one command and returns at the edge where its transfer happens.
	task automatic send_command(input rws_pkg::opcode_t op, input logic fst,
			input logic [31:0] pred, input logic [13:0] r);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			if (start_level) begin
				start       <= 1'b0;
				start_level  = 1'b0;
			end
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start            <= 1'b1;
		start_level       = 1'b1;
		opcode           <= op;
		first            <= fst;
		predicted_length <= pred;
		draw             <= r;
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (op == rws_pkg::OP_LOAD) begin
			loads_sent++;
		end else begin
			draws_sent++;
			if (r > rws_pkg::DRAW_SCALE) begin
				wide_draws++;
			end
		end
	endtask

	// Holds off new commands until every outstanding result has been seen.
	task automatic wait_for_results();
		if (start_level) begin
			start       <= 1'b0;
			start_level  = 1'b0;
		end
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_target(input logic [31:0] value);
		wait_for_results();
		cfg_we        <= 1'b1;
		target_length <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		targets_written++;
	endtask

	// Stimulus: directed corners first, then random populations and draws.
	initial begin
		logic [31:0] goal;
		logic [31:0] offset;
		logic [31:0] pred;
		logic [13:0] r;
		logic        fst;
		int          phase_items;
		int          pop;
		int          spread;
		int          draw_count;
		bit          oversize_done;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		target_length    = '0;
		start            = 1'b0;
		opcode           = rws_pkg::OP_LOAD;
		first            = 1'b0;
		predicted_length = '0;
		draw             = '0;
		start_level      = 1'b0;
		idle_on          = 1'b1;
		oversize_done    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws on an empty store, then a small population with extreme errors.
		write_target(32'h0000_0000);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd0);
		send_command(rws_pkg::OP_DRAW, 1'b1, 32'h0, 14'd16383);
		send_command(rws_pkg::OP_LOAD, 1'b1, 32'h0000_0000, 14'd0);
		send_command(rws_pkg::OP_LOAD, 1'b0, 32'h0001_0000, 14'h3FFF);
		send_command(rws_pkg::OP_LOAD, 1'b0, 32'hFFFF_FFFF, 14'd0);
		send_command(rws_pkg::OP_LOAD, 1'b0, 32'h0000_8000, 14'd0);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd0);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd1);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'hFFFF_FFFF, 14'd5000);
		send_command(rws_pkg::OP_DRAW, 1'b1, 32'h0, 14'd9999);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd10000);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd10001);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd16383);
		// A population whose fitness all rounds to zero.
		send_command(rws_pkg::OP_LOAD, 1'b1, 32'hFFFF_FFFF, 14'd0);
		send_command(rws_pkg::OP_LOAD, 1'b0, 32'h8000_0000, 14'd0);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd5000);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd0);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd10000);
		// Largest target.
		write_target(32'hFFFF_FFFF);
		send_command(rws_pkg::OP_LOAD, 1'b1, 32'hFFFF_FFFF, 14'd0);
		send_command(rws_pkg::OP_LOAD, 1'b0, 32'h0000_0000, 14'd0);
		send_command(rws_pkg::OP_LOAD, 1'b0, 32'hFFFE_FFFF, 14'd0);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd16383);
		send_command(rws_pkg::OP_DRAW, 1'b0, 32'h0, 14'd4000);

		// Random phases, each with its own target; the last one adds no random idle gaps.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 3)
				0: goal = $urandom;
				1: goal = $urandom_range(0, 32'h00FF_FFFF);
				default: goal = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
			endcase
			write_target(goal);
			idle_on     = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				// Mostly small populations, sometimes enough to overfill the store.
				if (!oversize_done || $urandom_range(0, 5) == 0) begin
					pop = $urandom_range(28, 36);
				end else begin
					pop = $urandom_range(1, 8);
				end
				oversize_done = 1'b1;
				spread = $urandom_range(0, 22);
				for (int i = 0; i < pop; i++) begin
					offset = $urandom_range(0, 32'h1 << spread);
					pred   = $urandom_range(0, 1) ? goal + offset : goal - offset;
					if ($urandom_range(0, 7) == 0) begin
						pred = $urandom;
					end
					// An occasional population extends the previous one.
					fst = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
					send_command(rws_pkg::OP_LOAD, fst, pred, 14'($urandom));
					phase_items++;
				end
				draw_count = $urandom_range(1, 10);
				for (int i = 0; i < draw_count; i++) begin
					case ($urandom_range(0, 9))
						0: r = 14'd0;
						1: r = 14'($urandom_range(10001, 16383));
						2: r = 14'd10000;
						default: r = 14'($urandom_range(0, 10000));
					endcase
					send_command(rws_pkg::OP_DRAW, 1'($urandom), $urandom, r);
					phase_items++;
				end
				if ($urandom_range(0, 9) == 0) begin
					wait_for_results();
				end
			end
		end

		// Let the last results come out, then settle.
		wait_for_results();
		repeat (40) @(posedge clk);

		$display("Run covered %0d loads and %0d draws (%0d with r above the scale)",
			loads_sent, draws_sent, wide_draws);
		$display("across %0d target settings, including both extremes.", targets_written);
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Stops a run that hangs.
	initial begin
		watchdog_cycles = 0;
		while (watchdog_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			watchdog_cycles++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.",
			watchdog_cycles, pending);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
